/* design/svm_pkg.sv */
// Types and fixed constants shared by the sample voice mixer.
package svm_pkg;

  localparam int MODE_W   = 2;
  localparam int SLOT_W   = 4;
  localparam int ADDR_W   = 12;
  localparam int PCM_W    = 16;
  localparam int LEN_W    = 13;
  localparam int STEP_W   = 24;
  localparam int GAIN_W   = 7;
  localparam int POS_W    = 29;
  localparam int FRAC_W   = 16;
  localparam int COUNT_W  = 4;

  localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TRIGGER = 2'd1;
  localparam logic [MODE_W-1:0] MODE_STOP    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RENDER  = 2'd3;

  // floor(2^29 / 127), used for the divide by 127 with one correction
  localparam logic [23:0] RECIP_127 = 24'd4227330;
  localparam int          RECIP_SH  = 29;

  localparam logic signed [PCM_W-1:0] PCM_MAX = 16'sd32767;
  localparam logic signed [PCM_W-1:0] PCM_MIN = -16'sd32768;

  typedef struct packed {
    logic [MODE_W-1:0]       mode;
    logic [SLOT_W-1:0]       slot;
    logic [ADDR_W-1:0]       frame_address;
    logic signed [PCM_W-1:0] pcm_value;
    logic [LEN_W-1:0]        slot_length;
    logic [STEP_W-1:0]       step;
    logic [GAIN_W-1:0]       gain;
  } in_item_t;

  typedef struct packed {
    logic signed [PCM_W-1:0] left_sample;
    logic signed [PCM_W-1:0] right_sample;
    logic [COUNT_W-1:0]      active_voices;
  } out_item_t;

endpackage

/* design/sample_voice_mixer.sv */
// Polyphonic sample player: sample memory, voice table and render sequencer.
//
// Load, trigger and stop transactions complete in the cycle they are accepted.
// A render transaction walks the voices in order through one shared multiplier:
// an idle voice is only checked and skipped, while an active voice takes two
// reads of the sample memory's one read port, then interpolation, gain and
// divide-by-127 on the multiplier, then accumulate and advance. The mix is then
// saturated into the output register, which waits while an old result is held;
// the next transaction is accepted once the result sits in the output register.
// The sample memory is not cleared; play only frames that were loaded.
module sample_voice_mixer #(
  parameter int VOICES          = 8,
  parameter int SLOTS           = 16,
  parameter int FRAMES_PER_SLOT = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  svm_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output svm_pkg::out_item_t out_data
);

  localparam int MEM_DEPTH = SLOTS * FRAMES_PER_SLOT;
  localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int VW        = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int ACC_W     = 18 + $clog2(VOICES + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ADDR = 3'd1;
  localparam logic [2:0] ST_RD1  = 3'd2;
  localparam logic [2:0] ST_MUL1 = 3'd3;
  localparam logic [2:0] ST_MUL2 = 3'd4;
  localparam logic [2:0] ST_MUL3 = 3'd5;
  localparam logic [2:0] ST_ACC  = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  // sample memory
  logic signed [svm_pkg::PCM_W-1:0] mem [MEM_DEPTH];
  logic                             wr_en;
  logic [MEM_AW-1:0]                wr_addr, rd_addr;
  logic signed [svm_pkg::PCM_W-1:0] rd_data_r;

  // voice table
  logic [VOICES-1:0]               act_r, act_nxt;
  logic [svm_pkg::SLOT_W-1:0]      vslot_r [VOICES];
  logic [svm_pkg::LEN_W-1:0]       vlen_r  [VOICES];
  logic [svm_pkg::STEP_W-1:0]      vstep_r [VOICES];
  logic [svm_pkg::GAIN_W-1:0]      vgain_r [VOICES];
  logic [svm_pkg::POS_W-1:0]       vpos_r  [VOICES];

  logic [2:0]                       state_r, state_nxt;
  logic [VW-1:0]                    v_r, v_nxt;
  logic signed [ACC_W-1:0]          acc_r, acc_nxt;
  logic [svm_pkg::COUNT_W-1:0]      cnt_r, cnt_nxt;
  logic signed [svm_pkg::PCM_W-1:0] s0_r;
  logic signed [33:0]               prod_r;
  logic                             neg_r;
  logic [22:0]                      t_r;
  logic [16:0]                      q0_r;
  logic                             out_valid_r;
  svm_pkg::out_item_t               out_r;

  logic signed [32:0]               mul_a;
  logic signed [23:0]               mul_b;
  logic signed [56:0]               mul_p;

  logic                             acc_in;
  logic                             trig_ok;
  logic [VW-1:0]                    pick;
  logic [svm_pkg::LEN_W-1:0]        trig_len;
  logic [svm_pkg::LEN_W-1:0]        idx, nidx;
  logic [svm_pkg::FRAC_W-1:0]       frac;
  logic signed [33:0]               val;
  logic [31:0]                      mag;
  logic [22:0]                      rem;
  logic [16:0]                      q;
  logic signed [ACC_W-1:0]          contrib;
  logic [svm_pkg::POS_W-1:0]        pos_new;
  logic                             last_v;

  assign in_ready  = (state_r == ST_IDLE);
  assign acc_in    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign idx    = vpos_r[v_r][svm_pkg::POS_W-1:svm_pkg::FRAC_W];
  assign frac   = vpos_r[v_r][svm_pkg::FRAC_W-1:0];
  assign nidx   = (({1'b0, idx} + 14'd1) < {1'b0, vlen_r[v_r]}) ? idx + 1'b1 : idx;
  assign last_v = (v_r == VW'(VOICES - 1));

  always_comb begin
    rd_addr = MEM_AW'(32'(vslot_r[v_r]) * FRAMES_PER_SLOT + 32'(idx));
    if (state_r == ST_RD1) begin
      rd_addr = MEM_AW'(32'(vslot_r[v_r]) * FRAMES_PER_SLOT + 32'(nidx));
    end
    wr_addr = MEM_AW'(32'(in_data.slot) * FRAMES_PER_SLOT + 32'(in_data.frame_address));
    wr_en   = acc_in && (in_data.mode == svm_pkg::MODE_LOAD)
              && (32'(in_data.slot) < SLOTS)
              && (32'(in_data.frame_address) < FRAMES_PER_SLOT);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_data.pcm_value;
    end
    rd_data_r <= mem[rd_addr];
  end

  // first free voice, voice 0 when all busy
  always_comb begin
    pick = '0;
    for (int i = VOICES - 1; i >= 0; i--) begin
      if (!act_r[i]) begin
        pick = VW'(i);
      end
    end
    trig_ok  = (32'(in_data.slot) < SLOTS) && (in_data.slot_length != '0);
    trig_len = in_data.slot_length;
    if (32'(in_data.slot_length) > FRAMES_PER_SLOT) begin
      trig_len = svm_pkg::LEN_W'(FRAMES_PER_SLOT);
    end
  end

  // shared multiplier
  always_comb begin
    mul_a = 33'(signed'({1'b0, rd_data_r}) - signed'({1'b0, s0_r}));
    mul_b = 24'(signed'({1'b0, frac}));
    case (state_r)
      ST_MUL1: begin
        mul_a = 33'(signed'(17'(rd_data_r) - 17'(s0_r)));
        mul_b = signed'({8'd0, frac});
      end
      ST_MUL2: begin
        mul_a = signed'({1'b0, mag});
        mul_b = signed'({17'd0, vgain_r[v_r]});
      end
      ST_MUL3: begin
        mul_a = signed'({10'd0, t_r});
        mul_b = signed'(svm_pkg::RECIP_127);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  always_comb begin
    val     = (34'(s0_r) <<< svm_pkg::FRAC_W) + prod_r;
    mag     = val[33] ? 32'(-val) : 32'(val);
    rem     = t_r - (23'(q0_r) << 7) + 23'(q0_r);
    q       = (rem >= 23'd127) ? q0_r + 17'd1 : q0_r;
    contrib = neg_r ? -ACC_W'(q) : ACC_W'(q);
    pos_new = vpos_r[v_r] + svm_pkg::POS_W'(vstep_r[v_r]);
  end

  always_comb begin
    state_nxt = state_r;
    v_nxt     = v_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    act_nxt   = act_r;
    case (state_r)
      ST_IDLE: begin
        if (acc_in) begin
          case (in_data.mode)
            svm_pkg::MODE_TRIGGER: begin
              if (trig_ok) begin
                act_nxt[pick] = 1'b1;
              end
            end
            svm_pkg::MODE_STOP: begin
              for (int i = 0; i < VOICES; i++) begin
                if (vslot_r[i] == in_data.slot) begin
                  act_nxt[i] = 1'b0;
                end
              end
            end
            svm_pkg::MODE_RENDER: begin
              state_nxt = ST_ADDR;
              v_nxt     = '0;
              acc_nxt   = '0;
              cnt_nxt   = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_ADDR: begin
        if (act_r[v_r]) begin
          state_nxt = ST_RD1;
        end else if (last_v) begin
          state_nxt = ST_OUT;
        end else begin
          v_nxt = v_r + 1'b1;
        end
      end
      ST_RD1:  state_nxt = ST_MUL1;
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_MUL3;
      ST_MUL3: state_nxt = ST_ACC;
      ST_ACC: begin
        acc_nxt = acc_r + contrib;
        if (pos_new >= {vlen_r[v_r], {svm_pkg::FRAC_W{1'b0}}}) begin
          act_nxt[v_r] = 1'b0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (last_v) begin
          state_nxt = ST_OUT;
        end else begin
          v_nxt     = v_r + 1'b1;
          state_nxt = ST_ADDR;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      v_r         <= '0;
      acc_r       <= '0;
      cnt_r       <= '0;
      act_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < VOICES; i++) begin
        vslot_r[i] <= '0;
        vlen_r[i]  <= '0;
        vstep_r[i] <= '0;
        vgain_r[i] <= '0;
        vpos_r[i]  <= '0;
      end
    end else begin
      state_r <= state_nxt;
      v_r     <= v_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      act_r   <= act_nxt;
      if (acc_in && in_data.mode == svm_pkg::MODE_TRIGGER && trig_ok) begin
        vslot_r[pick] <= in_data.slot;
        vlen_r[pick]  <= trig_len;
        vstep_r[pick] <= in_data.step;
        vgain_r[pick] <= in_data.gain;
        vpos_r[pick]  <= '0;
      end
      if (state_r == ST_ACC) begin
        vpos_r[v_r] <= pos_new;
      end
      if (state_r == ST_OUT && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    if (state_r == ST_RD1) begin
      s0_r <= rd_data_r;
    end
    if (state_r == ST_MUL1) begin
      prod_r <= mul_p[33:0];
    end
    if (state_r == ST_MUL2) begin
      neg_r <= val[33];
      t_r   <= mul_p[38:16];
    end
    if (state_r == ST_MUL3) begin
      q0_r <= mul_p[svm_pkg::RECIP_SH+16:svm_pkg::RECIP_SH];
    end
    if (state_r == ST_OUT && (!out_valid_r || out_ready)) begin
      if (acc_r > ACC_W'(svm_pkg::PCM_MAX)) begin
        out_r.left_sample  <= svm_pkg::PCM_MAX;
        out_r.right_sample <= svm_pkg::PCM_MAX;
      end else if (acc_r < ACC_W'(svm_pkg::PCM_MIN)) begin
        out_r.left_sample  <= svm_pkg::PCM_MIN;
        out_r.right_sample <= svm_pkg::PCM_MIN;
      end else begin
        out_r.left_sample  <= acc_r[svm_pkg::PCM_W-1:0];
        out_r.right_sample <= acc_r[svm_pkg::PCM_W-1:0];
      end
      out_r.active_voices <= cnt_r;
    end
  end

  a_render_start: assert property (@(posedge clk) disable iff (!rst_n)
    acc_in && in_data.mode == svm_pkg::MODE_RENDER |=> state_r == ST_ADDR && v_r == '0)
    else $error("render did not start at voice 0");

  a_div_fix: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ACC |-> rem < 23'd254)
    else $error("divide by 127 needs more than one correction");

  a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_OUT)
    else $error("result shown outside output state");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> !in_ready)
    else $error("input taken during render");

endmodule

/* test/tb_top.sv */
// Self-checking testbench for the sample voice mixer: directed and random traffic.
`timescale 1ns / 100ps

module tb_top;

  localparam int NV = 8;
  localparam int NS = 16;
  localparam int NF = 4096;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  svm_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  svm_pkg::out_item_t out_data;

  sample_voice_mixer DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic signed [15:0] pcm_mem [int];
  bit                 v_on  [NV];
  logic [3:0]         v_slot[NV];
  logic [12:0]        v_len [NV];
  logic [23:0]        v_step[NV];
  logic [6:0]         v_gain[NV];
  longint             v_pos [NV];

  svm_pkg::in_item_t  pending_items[$];
  svm_pkg::out_item_t expected_frames[$];
  int                 err_count = 0;
  bit                 stim_done = 1'b0;

  // frames that have been written, per slot (used to keep playback in loaded data)
  int        loaded_len[NS];

  function automatic longint frame_at(int s, int idx);
    if (pcm_mem.exists(s * NF + idx)) return longint'(pcm_mem[s * NF + idx]);
    return 0;
  endfunction

  task automatic predict_item(input svm_pkg::in_item_t it);
    int     pick;
    int     ln;
    longint mix;
    longint idx, nxt, f, s0, s1, val, mag, q;
    int     cnt;
    svm_pkg::out_item_t r;
    case (it.mode)
      svm_pkg::MODE_LOAD:
        pcm_mem[int'(it.slot) * NF + int'(it.frame_address)] = it.pcm_value;
      svm_pkg::MODE_TRIGGER: begin
        if (it.slot_length != 0) begin
          ln = (int'(it.slot_length) > NF) ? NF : int'(it.slot_length);
          pick = 0;
          for (int v = NV - 1; v >= 0; v--) if (!v_on[v]) pick = v;
          v_on[pick] = 1'b1;
          v_slot[pick] = it.slot;
          v_len[pick] = 13'(ln);
          v_step[pick] = it.step;
          v_gain[pick] = it.gain;
          v_pos[pick] = 0;
        end
      end
      svm_pkg::MODE_STOP: begin
        for (int v = 0; v < NV; v++) if (v_on[v] && v_slot[v] == it.slot) v_on[v] = 1'b0;
      end
      default: begin
        mix = 0;
        cnt = 0;
        for (int v = 0; v < NV; v++) begin
          if (v_on[v]) begin
            idx = v_pos[v] >> 16;
            f = v_pos[v] & 64'hFFFF;
            nxt = (idx + 1 < longint'(v_len[v])) ? idx + 1 : idx;
            s0 = frame_at(int'(v_slot[v]), int'(idx));
            s1 = frame_at(int'(v_slot[v]), int'(nxt));
            val = s0 * 65536 + (s1 - s0) * f;
            mag = (val < 0) ? -val : val;
            q = (mag * longint'(v_gain[v])) / (longint'(65536) * 127);
            mix += (val < 0) ? -q : q;
            v_pos[v] += longint'(v_step[v]);
            if (v_pos[v] >= (longint'(v_len[v]) << 16)) v_on[v] = 1'b0;
            else cnt++;
          end
        end
        if (mix > 32767) mix = 32767;
        if (mix < -32768) mix = -32768;
        r.left_sample = mix[15:0];
        r.right_sample = mix[15:0];
        r.active_voices = cnt[3:0];
        expected_frames.push_back(r);
      end
    endcase
  endtask

  function automatic int gap_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // acceptance is sampled at the rising edge; driver acts on it at the next falling edge
  bit in_taken = 1'b0;

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      predict_item(in_data);
    end
    in_taken <= rst_n && in_valid && in_ready;
  end

  // driver
  int send_gap = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_taken) begin
        // hold until accepted
      end else if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_items.size() > 0) begin
        in_data <= pending_items.pop_front();
        in_valid <= 1'b1;
        send_gap <= gap_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  int stall = 0;
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_frames.size() == 0) begin
        err_count++;
        if (err_count <= 10) $display("unexpected output frame %p", out_data);
      end else begin
        svm_pkg::out_item_t e;
        e = expected_frames.pop_front();
        if (out_data !== e) begin
          err_count++;
          if (err_count <= 10)
            $display("mismatch: expected L=%0d R=%0d n=%0d, got L=%0d R=%0d n=%0d",
                     e.left_sample, e.right_sample, e.active_voices,
                     out_data.left_sample, out_data.right_sample, out_data.active_voices);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (stall > 0) begin
      out_ready <= 1'b0;
      stall <= stall - 1;
    end else begin
      out_ready <= 1'b1;
      stall <= ($urandom_range(0, 3) == 0) ? gap_len() : 0;
    end
  end

  function automatic svm_pkg::in_item_t blank_item(logic [1:0] m);
    svm_pkg::in_item_t it;
    it = '0;
    it.mode = m;
    return it;
  endfunction

  function automatic svm_pkg::in_item_t random_noise();
    svm_pkg::in_item_t it;
    logic [95:0]       raw;
    raw = {$urandom, $urandom, $urandom};
    it = raw[$bits(svm_pkg::in_item_t)-1:0];
    return it;
  endfunction

  task automatic add_load(int s, int a, int v);
    svm_pkg::in_item_t it;
    it = blank_item(svm_pkg::MODE_LOAD);
    it.slot = 4'(s);
    it.frame_address = 12'(a);
    it.pcm_value = 16'(v);
    pending_items.push_back(it);
  endtask

  // callers are to keep length within what has been loaded in the slot; the task does not check it
  task automatic add_trigger(int s, int ln, int st, int g);
    svm_pkg::in_item_t it;
    it = blank_item(svm_pkg::MODE_TRIGGER);
    it.slot = 4'(s);
    it.slot_length = 13'(ln);
    it.step = 24'(st);
    it.gain = 7'(g);
    it.frame_address = 12'($urandom);
    it.pcm_value = 16'($urandom);
    pending_items.push_back(it);
  endtask

  task automatic add_simple(logic [1:0] m, int s);
    svm_pkg::in_item_t it;
    it = random_noise();
    it.mode = m;
    it.slot = 4'(s);
    pending_items.push_back(it);
  endtask

  initial begin
    int n;
    int s, ln;
    int kind;
    int a;
    for (int i = 0; i < NV; i++) begin
      v_on[i] = 1'b0; v_slot[i] = '0; v_len[i] = '0;
      v_step[i] = '0; v_gain[i] = '0; v_pos[i] = 0;
    end
    // slot 0 full-length extremes at ends, slot 1 short ramp
    add_load(0, 0, 32767);
    add_load(0, 1, -32768);
    add_load(0, 4095, -32768);
    add_load(1, 0, -32768);
    add_load(1, 1, 32767);
    add_load(1, 2, 0);
    add_trigger(1, 3, 32768, 127);
    add_simple(svm_pkg::MODE_RENDER, 0);
    add_simple(svm_pkg::MODE_RENDER, 0);
    add_trigger(1, 0, 65536, 127);      // empty length: ignored
    add_trigger(1, 2, 0, 127);          // zero step holds
    add_simple(svm_pkg::MODE_RENDER, 0);
    add_simple(svm_pkg::MODE_STOP, 1);
    add_simple(svm_pkg::MODE_RENDER, 0);
    // fill all voices at full gain, then steal voice 0
    for (int i = 0; i < 9; i++) add_trigger(1, 1, 0, 127);
    add_simple(svm_pkg::MODE_RENDER, 0);
    add_simple(svm_pkg::MODE_STOP, 1);
    add_trigger(0, 8191, 24'hFFFFFF, 0); // oversized length saturates; huge step
    add_simple(svm_pkg::MODE_RENDER, 0);
    // the voice has moved into unloaded frames
    add_simple(svm_pkg::MODE_STOP, 0);
    n = 0;
    for (int i = 0; i < NS; i++) loaded_len[i] = 0;
    loaded_len[1] = 3;
    // random phase: mostly well-formed load/trigger/render sequences
    while (n < 740) begin
      kind = $urandom_range(0, 99);
      s = $urandom_range(0, NS - 1);
      if (kind < 25) begin
        if (loaded_len[s] < 40) begin
          add_load(s, loaded_len[s], $urandom);
          loaded_len[s]++;
        end else if ($urandom_range(0, 20) == 0) begin
          add_load(s, $urandom_range(0, 4095), $urandom);  // may write high frames
        end else begin
          add_load(s, $urandom_range(0, loaded_len[s] - 1), $urandom);
        end
      end else if (kind < 45) begin
        if (loaded_len[s] > 0) begin
          ln = $urandom_range(0, loaded_len[s]);
          add_trigger(s, ln, ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 3 << 16),
                      ($urandom_range(0, 4) == 0) ? 127 : $urandom_range(0, 127));
        end else continue;
      end else if (kind < 50) begin
        add_simple(svm_pkg::MODE_STOP, s);
      end else begin
        add_simple(svm_pkg::MODE_RENDER, s);
      end
      n++;
    end
    // full-length playback of slot 0: load just the frames the two voices visit
    for (int k = 0; k <= 16; k++) begin
      a = int'((longint'(k) * longint'(24'hFFFFFF)) >> 16);
      add_load(0, a, $urandom);
      if (a + 1 < NF) add_load(0, a + 1, $urandom);
      add_load(0, k * 8, $urandom);
      add_load(0, k * 8 + 1, $urandom);
    end
    add_trigger(0, 4096, 24'hFFFFFF, 127);
    add_trigger(0, 4096, 24'h080000, 127);
    for (int i = 0; i < 18; i++) add_simple(svm_pkg::MODE_RENDER, 0);
    stim_done = 1'b1;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_done);
    @(posedge clk);
    while (pending_items.size() > 0 || in_valid || expected_frames.size() > 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
    if (err_count == 0 && expected_frames.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

/* sample_voice_mixer.f */
design/svm_pkg.sv
design/sample_voice_mixer.sv
test/tb_top.sv
